/* sv/head_tail_delimiter_deframer_macros.svh */
// Assertion macros used by the deframer RTL.
// Depends on nothing; included by the deframer module, which carries the assertions.
`ifndef HEAD_TAIL_DELIMITER_DEFRAMER_MACROS_SVH
`define HEAD_TAIL_DELIMITER_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTDD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HTDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/htdd_pkg.sv */
// Package for the head/tail delimiter deframer: widths, register indexes,
// window and configuration types, and the delimiter compare function.
package htdd_pkg;

  localparam int MAX_DELIM_BYTES = 8;
  localparam int BYTE_W          = 8;
  localparam int PAT_W           = MAX_DELIM_BYTES * BYTE_W;
  localparam int LEN_W           = 4;
  localparam int FILL_W          = $clog2(MAX_DELIM_BYTES + 1);
  localparam int IDX_W           = $clog2(MAX_DELIM_BYTES);
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 64;

  localparam logic [CFG_IDX_W-1:0] REG_HEAD_PATTERN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_LENGTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_PATTERN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_LENGTH  = CFG_IDX_W'(3);

  localparam logic [PAT_W-1:0] HEAD_PATTERN_RST = PAT_W'(0);
  localparam logic [LEN_W-1:0] HEAD_LENGTH_RST  = LEN_W'(0);
  localparam logic [PAT_W-1:0] TAIL_PATTERN_RST = PAT_W'(10);
  localparam logic [LEN_W-1:0] TAIL_LENGTH_RST  = LEN_W'(1);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DELIM_BYTES);

  // Byte window, entry 0 is the newest byte.
  typedef logic [MAX_DELIM_BYTES-1:0][BYTE_W-1:0] window_t;

  // Live configuration with lengths already clamped to their usable range.
  typedef struct packed {
    window_t          head_pattern;
    logic [LEN_W-1:0] head_len;
    window_t          tail_pattern;
    logic [LEN_W-1:0] tail_len;
    logic             clear;
  } cfg_t;

  // True when the newest len bytes of hist, oldest first, equal the first
  // len bytes of pat.
  function automatic logic match_last(window_t hist, window_t pat, logic [LEN_W-1:0] len);
    logic             ok;
    logic [LEN_W-1:0] k;
    ok = 1'b1;
    for (int j = 0; j < MAX_DELIM_BYTES; j++) begin
      k = len - LEN_W'(j) - LEN_W'(1);
      if ((LEN_W'(j) < len) && (hist[j] != pat[k[IDX_W-1:0]])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

/* sv/htdd_if.sv */
// Channel interfaces of the deframer: byte input, result output and
// configuration write. Depends on htdd_pkg for the field widths.
interface htdd_in_if;
  logic                         valid;
  logic                         ready;
  logic [htdd_pkg::BYTE_W-1:0]  data_byte;
  modport source (output valid, data_byte, input ready);
  modport sink (input valid, data_byte, output ready);
endinterface

interface htdd_out_if;
  logic                         valid;
  logic                         ready;
  logic [htdd_pkg::BYTE_W-1:0]  body_byte;
  logic                         byte_valid;
  logic                         end_of_packet;
  modport source (output valid, body_byte, byte_valid, end_of_packet, input ready);
  modport sink (input valid, body_byte, byte_valid, end_of_packet, output ready);
endinterface

interface htdd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [htdd_pkg::CFG_IDX_W-1:0]  index;
  logic [htdd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/head_tail_delimiter_deframer.sv */
// Head/tail delimiter deframer: an accepted byte is held in the input register, and
// its result is registered in the output register; throughput one byte per cycle
// while the output is not stalled, set by the window compare between the two registers.
// Bytes that cause no result do not load the output register.
// Reset (rst_n low, synchronous) returns to hunting with an empty window and
// restores the default delimiters; a write to a known register also empties the window.
`include "head_tail_delimiter_deframer_macros.svh"

module head_tail_delimiter_deframer (
  input  logic        clk,
  input  logic        rst_n,
  htdd_in_if.sink     in_if,
  htdd_out_if.source  out_if,
  htdd_cfg_if.sink    cfg_if
);
  import htdd_pkg::*;

  cfg_t              cfg;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              in_body_r, in_body_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  window_t           hist_r;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] body_byte_r, body_byte_nxt;
  logic              byte_valid_r, byte_valid_nxt;
  logic              eop_r, eop_nxt;

  logic              advance;
  window_t           hist_push;
  logic [FILL_W-1:0] head_fill;
  logic [FILL_W-1:0] body_fill;
  logic              head_hit;
  logic              tail_hit;
  logic              body_go;
  logic              emit;
  logic [LEN_W-1:0]  tail_last;

  htdd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  assign advance      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || advance;
  assign s1_valid_nxt = in_if.valid || (s1_valid_r && !advance);

  always_comb begin
    hist_push = window_t'({hist_r[MAX_DELIM_BYTES-2:0], s1_byte_r});
    head_fill = (fill_r == FILL_W'(MAX_DELIM_BYTES)) ? fill_r : fill_r + FILL_W'(1);
    head_hit  = (head_fill >= FILL_W'(cfg.head_len)) &&
                match_last(hist_push, cfg.head_pattern, cfg.head_len);
    body_go   = in_body_r || (cfg.head_len == LEN_W'(0));
    body_fill = in_body_r ? fill_r + FILL_W'(1) : FILL_W'(1);
    emit      = body_go && (body_fill >= FILL_W'(cfg.tail_len));
    tail_hit  = match_last(hist_push, cfg.tail_pattern, cfg.tail_len);
    tail_last = cfg.tail_len - LEN_W'(1);

    in_body_nxt    = in_body_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    body_byte_nxt  = body_byte_r;
    byte_valid_nxt = byte_valid_r;
    eop_nxt        = eop_r;

    if (advance) begin
      priority if (!body_go) begin
        in_body_nxt = head_hit;
        fill_nxt    = head_hit ? FILL_W'(0) : head_fill;
      end else if (!emit) begin
        in_body_nxt = 1'b1;
        fill_nxt    = body_fill;
      end else if (tail_hit) begin
        in_body_nxt    = 1'b0;
        fill_nxt       = FILL_W'(0);
        out_valid_nxt  = 1'b1;
        body_byte_nxt  = '0;
        byte_valid_nxt = 1'b0;
        eop_nxt        = 1'b1;
      end else begin
        in_body_nxt    = 1'b1;
        fill_nxt       = body_fill - FILL_W'(1);
        out_valid_nxt  = 1'b1;
        body_byte_nxt  = hist_push[tail_last[IDX_W-1:0]];
        byte_valid_nxt = 1'b1;
        eop_nxt        = 1'b0;
      end
    end

    if (cfg.clear) begin
      fill_nxt = FILL_W'(0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      in_body_r   <= 1'b0;
      fill_r      <= '0;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      in_body_r   <= in_body_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        hist_r <= hist_push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready) begin
      s1_byte_r <= in_if.data_byte;
    end
    body_byte_r  <= body_byte_nxt;
    byte_valid_r <= byte_valid_nxt;
    eop_r        <= eop_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.body_byte     = body_byte_r;
  assign out_if.byte_valid    = byte_valid_r;
  assign out_if.end_of_packet = eop_r;

  `HTDD_ASSERT_NOW(a_one_kind, clk, rst_n, out_valid_r, byte_valid_r != eop_r, "result is neither body byte nor end of packet")
  `HTDD_ASSERT_NOW(a_pending_below_tail, clk, rst_n, in_body_r, fill_r < FILL_W'(cfg.tail_len), "pending bytes reached the tail length")
  `HTDD_ASSERT_NEXT(a_eop_hunts, clk, rst_n, advance && emit && tail_hit, !in_body_r && out_valid_r && eop_r, "tail match did not end the packet")
  `HTDD_ASSERT_NEXT(a_hunt_silent, clk, rst_n, advance && !body_go, !out_valid_r, "hunting byte produced a result")

endmodule

/* sv/htdd_cfg_regs.sv */
// Configuration registers of the deframer with length clamping.
// Depends on htdd_pkg and the htdd_cfg_if interface.
module htdd_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  htdd_cfg_if.sink      cfg_if,
  output htdd_pkg::cfg_t cfg
);
  import htdd_pkg::*;

  window_t          head_pattern_r, head_pattern_nxt;
  logic [LEN_W-1:0] head_length_r, head_length_nxt;
  window_t          tail_pattern_r, tail_pattern_nxt;
  logic [LEN_W-1:0] tail_length_r, tail_length_nxt;
  logic             wr;
  logic             known;

  assign cfg_if.ready = 1'b1;
  assign wr = cfg_if.valid && cfg_if.ready;

  always_comb begin
    head_pattern_nxt = head_pattern_r;
    head_length_nxt  = head_length_r;
    tail_pattern_nxt = tail_pattern_r;
    tail_length_nxt  = tail_length_r;
    known            = 1'b1;
    unique case (cfg_if.index)
      REG_HEAD_PATTERN: head_pattern_nxt = window_t'(cfg_if.data[PAT_W-1:0]);
      REG_HEAD_LENGTH:  head_length_nxt  = cfg_if.data[LEN_W-1:0];
      REG_TAIL_PATTERN: tail_pattern_nxt = window_t'(cfg_if.data[PAT_W-1:0]);
      REG_TAIL_LENGTH:  tail_length_nxt  = cfg_if.data[LEN_W-1:0];
      default:          known            = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_pattern_r <= HEAD_PATTERN_RST;
      head_length_r  <= HEAD_LENGTH_RST;
      tail_pattern_r <= TAIL_PATTERN_RST;
      tail_length_r  <= TAIL_LENGTH_RST;
    end else if (wr) begin
      head_pattern_r <= head_pattern_nxt;
      head_length_r  <= head_length_nxt;
      tail_pattern_r <= tail_pattern_nxt;
      tail_length_r  <= tail_length_nxt;
    end
  end

  always_comb begin
    cfg.head_pattern = head_pattern_r;
    cfg.tail_pattern = tail_pattern_r;
    cfg.head_len     = (head_length_r > MAX_LEN) ? MAX_LEN : head_length_r;
    if (tail_length_r == LEN_W'(0)) begin
      cfg.tail_len = LEN_W'(1);
    end else if (tail_length_r > MAX_LEN) begin
      cfg.tail_len = MAX_LEN;
    end else begin
      cfg.tail_len = tail_length_r;
    end
    cfg.clear = wr && known;
  end

endmodule

/* bench/head_tail_delimiter_deframer_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for head_tail_delimiter_deframer: a queue-fed byte driver,
// a result monitor and an in-bench deframer model that predicts every result.
// Depends on htdd_pkg, the channel interfaces in htdd_if.sv and the deframer RTL.
module head_tail_delimiter_deframer_tb;
  import htdd_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1950;
  localparam int unsigned CHOKE_PHASE   = 2;
  localparam int unsigned CHOKE_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES  = 4;
  localparam int unsigned SETTLE_LIMIT  = 100000;
  localparam int unsigned FIRST_SPARE_REG = int'(REG_TAIL_LENGTH) + 1;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic              byte_valid;
    logic              end_of_packet;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  offer_valid = 1'b0;
  logic [BYTE_W-1:0]     offer_byte = '0;
  logic                  take_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  htdd_in_if  in_ch();
  htdd_out_if out_ch();
  htdd_cfg_if cfg_ch();

  assign in_ch.valid     = offer_valid;
  assign in_ch.data_byte = offer_byte;
  assign out_ch.ready    = take_ready;
  assign cfg_ch.valid    = cfg_valid;
  assign cfg_ch.index    = cfg_index;
  assign cfg_ch.data     = cfg_data;

  head_tail_delimiter_deframer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[head_tail_delimiter_deframer] ERROR");
    $finish;
  end

  // Deframer state as the block should hold it.
  logic [PAT_W-1:0]  cur_head_pattern = HEAD_PATTERN_RST;
  logic [LEN_W-1:0]  cur_head_length  = HEAD_LENGTH_RST;
  logic [PAT_W-1:0]  cur_tail_pattern = TAIL_PATTERN_RST;
  logic [LEN_W-1:0]  cur_tail_length  = TAIL_LENGTH_RST;
  bit                in_frame = 1'b0;
  logic [BYTE_W-1:0] held [MAX_DELIM_BYTES];
  int unsigned       held_count = 0;

  result_t           awaited_results[$];
  logic [BYTE_W-1:0] pending_bytes[$];
  int unsigned       bytes_queued = 0;
  int unsigned       bytes_accepted = 0;
  int unsigned       errors = 0;
  int unsigned       chokes_asked = 0;
  int unsigned       chokes_done = 0;
  bit                calm = 1'b0;

  function automatic int unsigned clamp_len(logic [LEN_W-1:0] v, int unsigned lo);
    if (v < lo) return lo;
    if (v > MAX_DELIM_BYTES) return MAX_DELIM_BYTES;
    return v;
  endfunction

  task automatic clear_held();
    for (int i = 0; i < MAX_DELIM_BYTES; i++) held[i] = '0;
    held_count = 0;
  endtask

  task automatic drop_oldest_held();
    for (int i = 1; i < MAX_DELIM_BYTES; i++) held[i-1] = held[i];
    held[MAX_DELIM_BYTES-1] = '0;
    if (held_count > 0) held_count--;
  endtask

  task automatic hold_byte(logic [BYTE_W-1:0] b);
    if (held_count >= MAX_DELIM_BYTES) drop_oldest_held();
    held[held_count] = b;
    held_count++;
  endtask

  task automatic deframe_byte(logic [BYTE_W-1:0] b);
    int unsigned hl;
    int unsigned tl;
    bit          hit;
    result_t     r;
    hl = clamp_len(cur_head_length, 0);
    tl = clamp_len(cur_tail_length, 1);
    if (!in_frame) begin
      if (hl == 0) begin
        in_frame = 1'b1;
        held_count = 0;
      end else begin
        hold_byte(b);
        if (held_count < hl) return;
        hit = 1'b1;
        for (int i = 0; i < hl; i++) begin
          if (held[held_count - hl + i] != cur_head_pattern[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          in_frame = 1'b1;
          clear_held();
        end
        return;
      end
    end
    hold_byte(b);
    if (held_count < tl) return;
    hit = 1'b1;
    for (int i = 0; i < tl; i++) begin
      if (held[i] != cur_tail_pattern[8*i +: 8]) hit = 1'b0;
    end
    if (hit) begin
      r = '{body_byte: '0, byte_valid: 1'b0, end_of_packet: 1'b1};
      clear_held();
      in_frame = 1'b0;
    end else begin
      r = '{body_byte: held[0], byte_valid: 1'b1, end_of_packet: 1'b0};
      drop_oldest_held();
    end
    awaited_results.push_back(r);
  endtask

  always @(posedge clk) begin : byte_driver
    int unsigned gap_left;
    if (!rst_n) begin
      offer_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (offer_valid && in_ch.ready) begin
        deframe_byte(offer_byte);
        bytes_accepted++;
      end
      if (!offer_valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          offer_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          offer_valid <= 1'b1;
          offer_byte <= pending_bytes.pop_front();
          if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 18);
        end else begin
          offer_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    int unsigned hold_left;
    result_t     got;
    result_t     want;
    if (!rst_n) begin
      take_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && take_ready) begin
        got = '{body_byte: out_ch.body_byte, byte_valid: out_ch.byte_valid,
                end_of_packet: out_ch.end_of_packet};
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got byte=%02h valid=%0b eop=%0b",
                   $time, got.body_byte, got.byte_valid, got.end_of_packet);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (got.body_byte !== want.body_byte || got.byte_valid !== want.byte_valid ||
              got.end_of_packet !== want.end_of_packet) begin
            $display("%0t: result mismatch, expected byte=%02h valid=%0b eop=%0b, got byte=%02h valid=%0b eop=%0b",
                     $time, want.body_byte, want.byte_valid, want.end_of_packet,
                     got.body_byte, got.byte_valid, got.end_of_packet);
            errors++;
          end
        end
      end
      if (chokes_done != chokes_asked) begin
        chokes_done = chokes_asked;
        hold_left = CHOKE_CYCLES;
        take_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        take_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(0, 17);
        take_ready <= 1'b0;
      end else begin
        take_ready <= 1'b1;
      end
    end
  end

  // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_HEAD_PATTERN: cur_head_pattern = val;
      REG_HEAD_LENGTH:  cur_head_length = val[LEN_W-1:0];
      REG_TAIL_PATTERN: cur_tail_pattern = val;
      REG_TAIL_LENGTH:  cur_tail_length = val[LEN_W-1:0];
      default: ;
    endcase
    if (idx <= REG_TAIL_LENGTH) clear_held();
  endtask

  task automatic settle();
    int unsigned guard;
    guard = 0;
    while ((bytes_accepted != bytes_queued || awaited_results.size() != 0) &&
           guard < SETTLE_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_byte(logic [BYTE_W-1:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte(bit tight);
    int unsigned k;
    k = $urandom_range(0, MAX_DELIM_BYTES - 1);
    if (tight && $urandom_range(0, 1) == 1) begin
      return $urandom_range(0, 1) ? cur_head_pattern[8*k +: 8] : cur_tail_pattern[8*k +: 8];
    end
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [PAT_W-1:0] pick_pattern();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {MAX_DELIM_BYTES{b}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return LEN_W'($urandom_range(MAX_DELIM_BYTES + 1, (1 << LEN_W) - 1));
      default: return LEN_W'($urandom_range(1, MAX_DELIM_BYTES));
    endcase
  endfunction

  // Up to three random bytes, then one head, body and tail; a broken frame has one delimiter byte corrupted.
  task automatic queue_frame(bit broken, bit tight);
    int unsigned       hl;
    int unsigned       tl;
    int unsigned       bad_at;
    int unsigned       body_len;
    logic [BYTE_W-1:0] b;
    hl = clamp_len(cur_head_length, 0);
    tl = clamp_len(cur_tail_length, 1);
    bad_at = broken ? $urandom_range(0, hl + tl - 1) : hl + tl;
    repeat ($urandom_range(0, 3)) queue_byte(pick_byte(tight));
    for (int i = 0; i < hl; i++) begin
      b = cur_head_pattern[8*i +: 8];
      queue_byte(i == bad_at ? b ^ BYTE_W'($urandom_range(1, 255)) : b);
    end
    body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    repeat (body_len) queue_byte(pick_byte(tight));
    for (int i = 0; i < tl; i++) begin
      b = cur_tail_pattern[8*i +: 8];
      queue_byte(i + hl == bad_at ? b ^ BYTE_W'($urandom_range(1, 255)) : b);
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned random_start;
    bit          tight;
    clear_held();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default delimiters: no head and a single newline tail.
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h0A);
    queue_byte(8'h55);
    queue_byte(8'h0A);
    settle();

    // Oversized head length acts as eight bytes and a zero tail length as one.
    write_reg(REG_HEAD_PATTERN, '1);
    write_reg(REG_HEAD_LENGTH, 64'd15);
    write_reg(REG_TAIL_PATTERN, '0);
    write_reg(REG_TAIL_LENGTH, 64'd0);
    cfg_valid <= 1'b0;
    repeat (8) queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_byte(8'h00);
    settle();

    // Oversized tail length; a write to a spare index must keep the pending bytes.
    write_reg(REG_HEAD_PATTERN, '0);
    write_reg(REG_HEAD_LENGTH, 64'd1);
    write_reg(REG_TAIL_PATTERN, '1);
    write_reg(REG_TAIL_LENGTH, 64'd15);
    cfg_valid <= 1'b0;
    queue_byte(8'h00);
    repeat (4) queue_byte(8'hFF);
    settle();
    write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, (1 << CFG_IDX_W) - 1)),
              {$urandom, $urandom});
    cfg_valid <= 1'b0;
    repeat (4) queue_byte(8'hFF);

    phase = 0;
    random_start = bytes_queued;
    while (bytes_queued - random_start < RANDOM_ITEMS) begin
      settle();
      if (phase == CHOKE_PHASE) begin
        write_reg(REG_HEAD_LENGTH, '0);
        write_reg(REG_TAIL_LENGTH, CFG_DATA_W'(MAX_DELIM_BYTES));
        write_reg(REG_TAIL_PATTERN, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        chokes_asked++;
        repeat (80) queue_byte(BYTE_W'($urandom));
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 1) == 1) write_reg(REG_HEAD_PATTERN, pick_pattern());
          if ($urandom_range(0, 1) == 1) write_reg(REG_HEAD_LENGTH, CFG_DATA_W'(pick_length()));
          if ($urandom_range(0, 1) == 1) write_reg(REG_TAIL_PATTERN, pick_pattern());
          if ($urandom_range(0, 1) == 1) write_reg(REG_TAIL_LENGTH, CFG_DATA_W'(pick_length()));
          if ($urandom_range(0, 7) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, (1 << CFG_IDX_W) - 1)),
                      {$urandom, $urandom});
          end
        end
        cfg_valid <= 1'b0;
        tight = ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 8)) queue_frame($urandom_range(0, 6) == 0, tight);
      end
      if (bytes_queued - random_start > RANDOM_ITEMS * 7 / 8) calm = 1'b1;
      phase++;
    end

    settle();
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[head_tail_delimiter_deframer] OK");
    end else begin
      $display("[head_tail_delimiter_deframer] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/htdd_pkg.sv
sv/htdd_if.sv
sv/htdd_cfg_regs.sv
sv/head_tail_delimiter_deframer.sv
bench/head_tail_delimiter_deframer_tb.sv
